// File: hw/rtl/line_assembler_with_line_queue_defines.svh
// Assertion helpers used by the checker file laq_checker.sv.
`ifndef LINE_ASSEMBLER_WITH_LINE_QUEUE_DEFINES_SVH
`define LINE_ASSEMBLER_WITH_LINE_QUEUE_DEFINES_SVH

// same-cycle implication, off while in reset
`define LAQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define LAQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/laq_pkg.sv
package laq_pkg;

  localparam int LINE_MAX_DEF    = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic [6:0] pop_limit;
  } item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] line_char;
    logic       last_of_run;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_POP,
    ST_SINGLE
  } state_t;

endpackage

// File: hw/rtl/line_assembler_with_line_queue.sv
// Line assembler with a drop-oldest line queue.
// Input channel in_valid/in_ready/in_data: a word is either one received byte
// (operation 0) or a pop request with a buffer size (operation 1).
// Bytes gather in a partial-line RAM; CR or LF ends a non-empty line, which is
// then copied into a text RAM of QUEUE_DEPTH line slots, dropping the oldest
// line when all slots are taken.
// Output channel out_valid/out_ready/out_data: a pop returns the oldest line
// one character per word with last_of_run on the final word, or one word of
// kind "none" or "empty".
// Timing: a plain byte is written straight into the partial-line RAM. Ending a line
// copies it one byte per cycle through the partial-line RAM read port. A pop,
// once accepted, returns one character per cycle through the text RAM read port
// while out_ready stays high.
// A stalled receiver holds the output word and the pop sequence; byte words are
// still taken while a finished result waits, but not during a copy or a pop.
// Reset (rst_n low, synchronous) empties the queue and the partial line; no
// memory clearing pass is needed.
module line_assembler_with_line_queue
  import laq_pkg::*;
#(
  parameter int LINE_MAX    = LINE_MAX_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int LEN_W  = $clog2(LINE_MAX);
  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TA_W   = $clog2(QUEUE_DEPTH * LINE_MAX);
  localparam int CMP_W  = (LEN_W > 7) ? LEN_W : 7;

  localparam logic [LEN_W-1:0]  LEN_LAST  = LEN_W'(LINE_MAX - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(QUEUE_DEPTH);
  localparam logic [TA_W-1:0]   STRIDE    = TA_W'(LINE_MAX);

  // memories
  logic [7:0]       part_mem [LINE_MAX];
  logic [7:0]       text_mem [QUEUE_DEPTH * LINE_MAX];
  logic [LEN_W-1:0] qlen_r   [QUEUE_DEPTH];

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic             nul_seen_r, nul_seen_nxt;
  logic [LEN_W-1:0] nul_pos_r, nul_pos_nxt;
  logic [SLOT_W-1:0] wslot_r, wslot_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [LEN_W-1:0] wr_idx_r, wr_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_data_r, out_data_nxt;

  logic             pm_we, pm_re, tm_we, tm_re, qlen_we;
  logic [LEN_W-1:0] pm_waddr, pm_raddr;
  logic [TA_W-1:0]  tm_waddr, tm_raddr;
  logic [7:0]       pm_rdata_r, tm_rdata_r;

  logic             out_free, consume, issue;
  logic [CMP_W-1:0] lim_m1, qlen_ext;
  logic [TA_W-1:0]  wbase, rbase;

  assign out_free = !out_valid_r || out_ready;
  assign wbase    = TA_W'(wslot_r) * STRIDE;
  assign rbase    = TA_W'(rslot_r) * STRIDE;
  assign lim_m1   = CMP_W'(in_data.pop_limit) - CMP_W'(1);
  assign qlen_ext = CMP_W'(qlen_r[rslot_r]);

  always_ff @(posedge clk) begin
    if (pm_we) begin
      part_mem[pm_waddr] <= in_data.rx_byte;
    end
    if (pm_re) begin
      pm_rdata_r <= part_mem[pm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      text_mem[tm_waddr] <= pm_rdata_r;
    end
    if (tm_re) begin
      tm_rdata_r <= text_mem[tm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (qlen_we) begin
      qlen_r[wslot_r] <= len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plen_r      <= '0;
      nul_seen_r  <= 1'b0;
      wslot_r     <= '0;
      rslot_r     <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      nul_seen_r  <= nul_seen_nxt;
      wslot_r     <= wslot_nxt;
      rslot_r     <= rslot_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nul_pos_r  <= nul_pos_nxt;
    len_r      <= len_nxt;
    rd_idx_r   <= rd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    kind_r     <= kind_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    plen_nxt      = plen_r;
    nul_seen_nxt  = nul_seen_r;
    nul_pos_nxt   = nul_pos_r;
    wslot_nxt     = wslot_r;
    rslot_nxt     = rslot_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    pend_nxt      = pend_r;
    kind_nxt      = kind_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    pm_we         = 1'b0;
    pm_re         = 1'b0;
    tm_we         = 1'b0;
    tm_re         = 1'b0;
    qlen_we       = 1'b0;
    pm_waddr      = plen_r;
    pm_raddr      = rd_idx_r;
    tm_waddr      = wbase + TA_W'(wr_idx_r);
    tm_raddr      = rbase + TA_W'(rd_idx_r);
    consume       = 1'b0;
    issue         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.operation == OP_BYTE) begin
            if (in_data.rx_byte == CH_CR || in_data.rx_byte == CH_LF) begin
              if (plen_r != '0) begin
                // cut at the first zero byte
                len_nxt      = nul_seen_r ? nul_pos_r : plen_r;
                rd_idx_nxt   = '0;
                pend_nxt     = 1'b0;
                plen_nxt     = '0;
                nul_seen_nxt = 1'b0;
                state_nxt    = ST_COPY;
              end
            end else if (plen_r != LEN_LAST) begin
              pm_we    = 1'b1;
              plen_nxt = plen_r + 1'b1;
              if (in_data.rx_byte == CH_NUL && !nul_seen_r) begin
                nul_seen_nxt = 1'b1;
                nul_pos_nxt  = plen_r;
              end
            end else begin
              // overlong line: drop it together with this byte
              plen_nxt     = '0;
              nul_seen_nxt = 1'b0;
            end
          end else begin
            if (in_data.pop_limit == '0 || count_r == '0) begin
              kind_nxt  = KIND_NONE;
              state_nxt = ST_SINGLE;
            end else begin
              // limit above LINE_MAX needs no clamp: stored length stays below it
              len_nxt    = (qlen_ext < lim_m1) ? LEN_W'(qlen_ext) : LEN_W'(lim_m1);
              rd_idx_nxt = '0;
              pend_nxt   = 1'b0;
              if (qlen_ext == '0 || lim_m1 == '0) begin
                kind_nxt  = KIND_EMPTY;
                state_nxt = ST_SINGLE;
              end else begin
                state_nxt = ST_POP;
              end
            end
          end
        end
      end

      ST_COPY: begin
        tm_we = pend_r;
        if (rd_idx_r != len_r) begin
          pm_re      = 1'b1;
          wr_idx_nxt = rd_idx_r;
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          qlen_we   = 1'b1;
          wslot_nxt = (wslot_r == SLOT_LAST) ? '0 : wslot_r + 1'b1;
          if (count_r == DEPTH_C) begin
            // queue full: drop the oldest line
            rslot_nxt = (rslot_r == SLOT_LAST) ? '0 : rslot_r + 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_POP: begin
        consume = pend_r && out_free;
        issue   = (!pend_r || consume) && (rd_idx_r != len_r);
        if (consume) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.result_kind = KIND_CHAR;
          out_data_nxt.line_char   = tm_rdata_r;
          out_data_nxt.last_of_run = (rd_idx_r == len_r);
        end
        if (issue) begin
          tm_re      = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end else if (consume) begin
          pend_nxt = 1'b0;
        end
        if (consume && rd_idx_r == len_r) begin
          rslot_nxt = (rslot_r == SLOT_LAST) ? '0 : rslot_r + 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_SINGLE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.result_kind = kind_r;
          out_data_nxt.line_char   = CH_NUL;
          out_data_nxt.last_of_run = 1'b1;
          if (kind_r == KIND_EMPTY) begin
            rslot_nxt = (rslot_r == SLOT_LAST) ? '0 : rslot_r + 1'b1;
            count_nxt = count_r - 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/laq_checker.sv
`include "line_assembler_with_line_queue_defines.svh"

module laq_checker
  import laq_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input item_t   in_data,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  `LAQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")
  `LAQ_ASSERT_IMP(a_single_last, clk, rst_n, out_valid && out_data.result_kind != KIND_CHAR, out_data.last_of_run, "none or empty result without last mark")
  `LAQ_ASSERT_IMP(a_single_zero, clk, rst_n, out_valid && out_data.result_kind != KIND_CHAR, out_data.line_char == CH_NUL, "none or empty result with nonzero character")
  `LAQ_ASSERT_NXT(a_pop_busy, clk, rst_n, in_valid && in_ready && in_data.operation == OP_POP, !in_ready, "new word taken right after a pop")

endmodule

bind line_assembler_with_line_queue laq_checker u_laq_checker (.*);

// File: bench/line_queue_checker.sv
module line_queue_checker
  import laq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  item_t       in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_data,
  output int unsigned mismatches,
  output int unsigned words_waiting,
  output int unsigned words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LMAX = LINE_MAX_DEF;
  localparam int QD   = QUEUE_DEPTH_DEF;

  logic [7:0]  partial_buf [LMAX];
  int          partial_len;
  logic [7:0]  slot_text [QD][LMAX];
  int          slot_len [QD];
  int          head_slot;
  int          tail_slot;
  int          lines_held;
  result_t     pending_words [$];
  result_t     want;
  int unsigned fail_cnt    = 0;
  int unsigned checked_cnt = 0;

  task automatic expect_word(input logic [1:0] kind, input logic [7:0] ch, input logic last);
    result_t w;
    w.result_kind = kind;
    w.line_char   = ch;
    w.last_of_run = last;
    pending_words.push_back(w);
  endtask

  task automatic predict_word(input item_t w);
    int keep;
    int lim;
    int n;
    if (w.operation == OP_BYTE) begin
      if (w.rx_byte == CH_CR || w.rx_byte == CH_LF) begin
        if (partial_len > 0) begin
          // the stored line stops at the first zero byte
          keep = 0;
          while (keep < partial_len && keep < LMAX - 1 && partial_buf[keep] != CH_NUL)
            keep++;
          if (lines_held >= QD) begin
            head_slot = (head_slot + 1) % QD;
            lines_held--;
          end
          for (int i = 0; i < keep; i++)
            slot_text[tail_slot][i] = partial_buf[i];
          slot_len[tail_slot] = keep;
          tail_slot = (tail_slot + 1) % QD;
          lines_held++;
          partial_len = 0;
        end
      end else if (partial_len < LMAX - 1) begin
        partial_buf[partial_len] = w.rx_byte;
        partial_len++;
      end else begin
        // overlong line: drop it along with this byte
        partial_len = 0;
      end
    end else begin
      lim = w.pop_limit;
      if (lim == 0 || lines_held == 0) begin
        expect_word(KIND_NONE, CH_NUL, 1'b1);
      end else begin
        if (lim > LMAX) lim = LMAX;
        n = (slot_len[head_slot] < lim - 1) ? slot_len[head_slot] : lim - 1;
        if (n == 0) begin
          expect_word(KIND_EMPTY, CH_NUL, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            expect_word(KIND_CHAR, slot_text[head_slot][i], (i == n - 1));
        end
        head_slot = (head_slot + 1) % QD;
        lines_held--;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      partial_len = 0;
      head_slot   = 0;
      tail_slot   = 0;
      lines_held  = 0;
      pending_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected result word: kind %0d, char 0x%02h, last %0b",
                 out_data.result_kind, out_data.line_char, out_data.last_of_run);
          fail_cnt++;
        end else begin
          want = pending_words.pop_front();
          checked_cnt++;
          if (out_data.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   out_data.result_kind);
            fail_cnt++;
          end
          if (out_data.line_char !== want.line_char) begin
            $error("line_char: expected 0x%02h, got 0x%02h", want.line_char,
                   out_data.line_char);
            fail_cnt++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   out_data.last_of_run);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready) predict_word(in_data);
    end
    mismatches    = fail_cnt;
    words_waiting = pending_words.size();
    words_checked = checked_cnt;
  end

endmodule

// File: bench/tb_line_assembler_with_line_queue.sv
module tb_line_assembler_with_line_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import laq_pkg::*;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        in_valid = 1'b0;
  item_t       in_data  = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  result_t     out_data;
  int unsigned mismatches;
  int unsigned words_waiting;
  int unsigned words_checked;

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  logic        hold_go    = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned words_sent = 0;
  int unsigned pops_sent  = 0;
  int unsigned cycle_count = 0;

  always #10 clk = ~clk;

  line_assembler_with_line_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  line_queue_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .words_waiting (words_waiting),
    .words_checked (words_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words outstanding", cycle_count,
               words_waiting);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic send_word(input item_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    item_t w;
    w.operation = OP_BYTE;
    w.rx_byte   = b;
    w.pop_limit = 7'($urandom_range(127));
    send_word(w);
  endtask

  task automatic send_pop(input logic [6:0] lim);
    item_t w;
    w.operation = OP_POP;
    w.rx_byte   = 8'($urandom_range(255));
    w.pop_limit = lim;
    send_word(w);
    pops_sent++;
  endtask

  function automatic logic [7:0] line_byte(input bit plain);
    int r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (!plain && r < 6) return CH_NUL;
    if (!plain && r < 9) return 8'($urandom_range(255));
    do b = 8'($urandom_range(1, 255)); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [6:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 7'(LINE_MAX_DEF);
    if (r < 70) return 7'($urandom_range(LINE_MAX_DEF));
    if (r < 85) return 7'($urandom_range(3));
    if (r < 95) return 7'($urandom_range(4, 20));
    return 7'($urandom_range(LINE_MAX_DEF + 1, 127));
  endfunction

  // plain lines carry no zero or terminator bytes and always end cleanly
  task automatic send_line(input int len, input bit plain);
    int r;
    for (int i = 0; i < len; i++) send_byte(line_byte(plain));
    r = $urandom_range(99);
    if (plain) begin
      send_byte(r < 50 ? CH_CR : CH_LF);
    end else if (r < 12) begin
      send_byte(CH_CR);
      send_byte(CH_LF);
    end else if (r < 56) begin
      send_byte(CH_CR);
    end else if (r < 96) begin
      send_byte(CH_LF);
    end
  endtask

  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                           input int unsigned stop_at);
    int r;
    int len;
    sender_idle_pct = s_idle;
    receiver_idle_pct <= r_idle;
    while (words_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(99);
        if (len < 58) len = $urandom_range(1, 6);
        else if (len < 92) len = $urandom_range(7, 20);
        else len = $urandom_range(LINE_MAX_DEF - 2, LINE_MAX_DEF + 1);
        send_line(len, 1'b0);
        if ($urandom_range(99) < 50) send_pop(pick_limit());
      end else if (r < 85) begin
        send_pop(pick_limit());
      end else if (r < 93) begin
        repeat ($urandom_range(2, 5)) send_pop(pick_limit());
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 16;
    receiver_idle_pct <= 68;
    @(negedge clk);

    send_pop(7'(LINE_MAX_DEF));
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_pop(7'd0);
    send_pop(7'd127);
    send_byte(CH_NUL);
    send_byte(CH_LF);
    send_pop(7'(LINE_MAX_DEF));
    send_byte(8'h61);
    send_byte(8'h7F);
    send_byte(CH_NUL);
    send_byte(8'h62);
    send_byte(CH_CR);
    send_pop(7'd1);
    // five lines into four slots: the first one falls out
    for (int k = 0; k < 5; k++) begin
      send_byte(8'(8'h30 + k));
      send_byte(CH_LF);
    end
    send_pop(7'(LINE_MAX_DEF));

    // longest line that fits, then one that overflows
    send_line(LINE_MAX_DEF - 1, 1'b1);
    send_pop(7'(LINE_MAX_DEF));
    send_line(LINE_MAX_DEF, 1'b1);

    run_phase(16, 68, 220);
    run_phase(68, 16, 340);
    hold_go <= 1'b1;
    run_phase(0, 0, 460);
    in_valid <= 1'b0;

    while (words_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d input words (%0d pops), checked %0d result words", words_sent,
             pops_sent, words_checked);
    $display("Idle mixes 16/68, 68/16 and none, with a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && words_waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/laq_pkg.sv
hw/rtl/line_assembler_with_line_queue.sv
hw/rtl/laq_checker.sv
bench/line_queue_checker.sv
bench/tb_line_assembler_with_line_queue.sv
